// ===== design/assert_macros.svh =====
// Assertion macros shared by the path prefix binding table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// plain invariant, checked every cycle outside reset
`define PPBT_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// same-cycle implication
`define PPBT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define PPBT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/ppbt_pkg.sv =====
// Types and constants of the path prefix binding table.
package ppbt_pkg;
	localparam int unsigned CMD_W = 2;
	localparam int unsigned STS_W = 3;
	localparam int unsigned ML_W = 5;
	localparam int unsigned HDL_W = 32;
	localparam logic [7:0] SLASH = 8'h2F;

	typedef enum logic [CMD_W-1:0] {
		CMD_BIND   = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_WCHECK = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [STS_W-1:0] {
		ST_OK       = 3'd0,
		ST_INVALID  = 3'd1,
		ST_TOO_LONG = 3'd2,
		ST_NO_SPACE = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_DENIED   = 3'd5
	} status_t;

	typedef struct packed {
		logic load;
		logic clr;
		logic cmp;
		logic scan_init;
		logic scan;
		logic dec;
		logic copy;
		logic commit;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic last_s1;
		logic scan_last;
		logic bind_go;
		logic copy_done;
		logic out_busy;
	} dp_sts_t;
endpackage

// ===== design/ppbt_ram.sv =====
// Generic single write, single read RAM with registered read data.
module ppbt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== design/ppbt_ctl.sv =====
// Sequencing state machine of the path prefix binding table.
module ppbt_ctl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_clear,
	output logic              in_ready,
	input  ppbt_pkg::dp_sts_t sts,
	output ppbt_pkg::dp_cmd_t cmd
);
	import ppbt_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_CMP  = 6'b000010,
		S_SCAN = 6'b000100,
		S_DEC  = 6'b001000,
		S_COPY = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_clear) begin
						cmd.clr = 1'b1;
						state_d = S_FIN;
					end else begin
						cmd.load = 1'b1;
						state_d = S_CMP;
					end
				end
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				cmd.scan_init = 1'b1;
				state_d = sts.last_s1 ? S_SCAN : S_IDLE;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				cmd.dec = 1'b1;
				state_d = sts.bind_go ? S_COPY : S_FIN;
			end
			S_COPY: begin
				cmd.copy = 1'b1;
				if (sts.copy_done) begin
					cmd.commit = 1'b1;
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`include "assert_macros.svh"
	`PPBT_ASSERT_NXT(a_bind_copy, (state_q == S_DEC) && sts.bind_go, state_q == S_COPY, "bind lost copy")
	`PPBT_ASSERT_IMP(a_commit_in_copy, cmd.commit, state_q == S_COPY, "commit outside copy")
endmodule

// ===== design/ppbt_dp.sv =====
// Datapath: binding store, per-character compare, scan and prefix copy.
module ppbt_dp #(
	parameter int unsigned MAX_BINDINGS = 8,
	parameter int unsigned PREFIX_CHARS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ppbt_pkg::dp_cmd_t               cmd,
	output ppbt_pkg::dp_sts_t               sts,
	input  logic [ppbt_pkg::CMD_W-1:0]      in_cmd,
	input  logic [7:0]                      in_ch,
	input  logic                            in_last,
	input  logic [ppbt_pkg::HDL_W-1:0]      in_handle,
	input  logic                            in_mode,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ppbt_pkg::STS_W-1:0]      out_status,
	output logic [ppbt_pkg::HDL_W-1:0]      out_handle,
	output logic [ppbt_pkg::ML_W-1:0]       out_length,
	output logic                            out_mode
);
	import ppbt_pkg::*;

	localparam int unsigned M  = MAX_BINDINGS;
	localparam int unsigned P  = PREFIX_CHARS;
	localparam int unsigned AW = $clog2(P);
	localparam int unsigned PW = $clog2(P + 1);
	localparam int unsigned EW = (M > 1) ? $clog2(M) : 1;

	logic [PW-1:0]    pos_q, p_s1, n, k_q;
	logic             bad_q, active_q;
	logic [M-1:0]     sm_q, bok_q, used_q, mode_q;
	logic [AW-1:0]    len_q [M];
	logic [HDL_W-1:0] hdl_q [M];
	logic [7:0]       ch_s1;
	logic [CMD_W-1:0] cmd_s1;
	logic             last_s1;
	logic [HDL_W-1:0] bh_q;
	logic             bm_q;
	logic [7:0]       rd_data [M];
	logic [7:0]       buf_data;

	logic [EW-1:0]    e_q, rep_q, free_q, slot_q;
	logic             best_v_q, rep_v_q, free_v_q;
	logic [AW-1:0]    best_len_q;
	logic [HDL_W-1:0] best_hdl_q;
	logic             best_mode_q;

	logic [STS_W-1:0] res_sts_q;
	logic [HDL_W-1:0] res_hdl_q;
	logic [AW-1:0]    res_len_q;
	logic             res_mode_q;
	logic             out_valid_q;

	logic             wr_s1;
	logic [AW-1:0]    wa_s1;
	logic             issue;

	logic [PW-1:0]    e_len;
	logic             e_match, e_rep;
	logic [STS_W-1:0] dec_sts;
	logic             bind_go;
	logic [EW-1:0]    dec_slot;
	logic [AW+ML_W-1:0] len_ext;

	assign n = pos_q;
	assign issue = cmd.copy && (k_q < n);

	// per-entry prefix character stores
	for (genvar g = 0; g < M; g++) begin : g_ent
		ppbt_ram #(.WIDTH(8), .DEPTH(P)) u_chars (
			.clk   (clk),
			.we    (wr_s1 && (slot_q == EW'(g))),
			.waddr (wa_s1),
			.wdata (buf_data),
			.re    (cmd.load),
			.raddr (pos_q[AW-1:0]),
			.rdata (rd_data[g])
		);
	end

	// characters of the current path
	ppbt_ram #(.WIDTH(8), .DEPTH(P)) u_inbuf (
		.clk   (clk),
		.we    (cmd.load && (pos_q < PW'(P))),
		.waddr (pos_q[AW-1:0]),
		.wdata (in_ch),
		.re    (issue),
		.raddr (k_q[AW-1:0]),
		.rdata (buf_data)
	);

	// scan view of entry e_q
	always_comb begin
		e_len = PW'(len_q[e_q]);
		e_match = used_q[e_q] && sm_q[e_q] &&
			((e_len == PW'(1)) || (n == e_len) || ((n > e_len) && bok_q[e_q]));
		e_rep = used_q[e_q] && sm_q[e_q] && (e_len == n);
	end

	// end-of-path decision
	always_comb begin
		dec_sts = ST_OK;
		bind_go = 1'b0;
		dec_slot = rep_v_q ? rep_q : free_q;
		unique case (cmd_t'(cmd_s1))
			CMD_BIND: begin
				priority if (bad_q) dec_sts = ST_INVALID;
				else if (n >= PW'(P)) dec_sts = ST_TOO_LONG;
				else if (rep_v_q || free_v_q) bind_go = 1'b1;
				else dec_sts = ST_NO_SPACE;
			end
			CMD_LOOKUP: begin
				priority if (bad_q) dec_sts = ST_INVALID;
				else if (!best_v_q) dec_sts = ST_NOT_FOUND;
				else dec_sts = ST_OK;
			end
			default: begin
				if (active_q && !bad_q && best_v_q && !best_mode_q) begin
					dec_sts = ST_DENIED;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			bad_q <= 1'b0;
			sm_q <= '1;
			bok_q <= '0;
			used_q <= '0;
			active_q <= 1'b0;
			out_valid_q <= 1'b0;
			wr_s1 <= 1'b0;
		end else begin
			if (cmd.cmp && (p_s1 < PW'(P))) begin
				if (p_s1 == '0) begin
					bad_q <= (ch_s1 != SLASH);
				end
				for (int e = 0; e < M; e++) begin
					if (p_s1 < PW'(len_q[e])) begin
						sm_q[e] <= sm_q[e] && (rd_data[e] == ch_s1);
					end else if (p_s1 == PW'(len_q[e])) begin
						bok_q[e] <= sm_q[e] && (ch_s1 == SLASH);
					end
				end
				pos_q <= p_s1 + PW'(1);
			end
			wr_s1 <= issue;
			if (cmd.commit) begin
				used_q[slot_q] <= 1'b1;
				active_q <= 1'b1;
			end
			if (cmd.clr) begin
				used_q <= '0;
				active_q <= 1'b0;
			end
			if (cmd.clr || cmd.finish) begin
				pos_q <= '0;
				bad_q <= 1'b0;
				sm_q <= '1;
				bok_q <= '0;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_s1 <= in_ch;
			cmd_s1 <= in_cmd;
			last_s1 <= in_last;
			p_s1 <= pos_q;
			bh_q <= in_handle;
			bm_q <= in_mode;
		end
		if (cmd.scan_init) begin
			e_q <= '0;
			best_v_q <= 1'b0;
			rep_v_q <= 1'b0;
			free_v_q <= 1'b0;
		end
		if (cmd.scan) begin
			e_q <= e_q + EW'(1);
			if (e_match && (!best_v_q || (len_q[e_q] > best_len_q))) begin
				best_v_q <= 1'b1;
				best_len_q <= len_q[e_q];
				best_hdl_q <= hdl_q[e_q];
				best_mode_q <= mode_q[e_q];
			end
			if (e_rep && !rep_v_q) begin
				rep_v_q <= 1'b1;
				rep_q <= e_q;
			end
			if (!used_q[e_q] && !free_v_q) begin
				free_v_q <= 1'b1;
				free_q <= e_q;
			end
		end
		if (cmd.dec) begin
			k_q <= '0;
			slot_q <= dec_slot;
			res_sts_q <= dec_sts;
			if ((cmd_t'(cmd_s1) == CMD_LOOKUP) && (dec_sts == ST_OK)) begin
				res_hdl_q <= best_hdl_q;
				res_len_q <= best_len_q;
				res_mode_q <= best_mode_q;
			end else begin
				res_hdl_q <= '0;
				res_len_q <= '0;
				res_mode_q <= 1'b0;
			end
		end
		if (cmd.clr) begin
			res_sts_q <= ST_OK;
			res_hdl_q <= '0;
			res_len_q <= '0;
			res_mode_q <= 1'b0;
		end
		if (issue) begin
			k_q <= k_q + PW'(1);
		end
		wa_s1 <= k_q[AW-1:0];
		if (cmd.commit) begin
			len_q[slot_q] <= n[AW-1:0];
			hdl_q[slot_q] <= bh_q;
			mode_q[slot_q] <= bm_q;
		end
		if (cmd.finish) begin
			out_status <= res_sts_q;
			out_handle <= res_hdl_q;
			out_length <= len_ext[ML_W-1:0];
			out_mode <= res_mode_q;
		end
	end

	assign len_ext = {{ML_W{1'b0}}, res_len_q};
	assign out_valid = out_valid_q;

	assign sts.last_s1 = last_s1;
	assign sts.scan_last = (e_q == EW'(M - 1));
	assign sts.bind_go = bind_go;
	assign sts.copy_done = !issue && !wr_s1;
	assign sts.out_busy = out_valid_q && !out_ready;

	`include "assert_macros.svh"
	`PPBT_ASSERT_IMP(a_no_overwrite, cmd.finish, !out_valid_q || out_ready, "result overwritten")
	`PPBT_ASSERT(a_pos_range, pos_q <= PW'(P), "position past end")
	`PPBT_ASSERT_NXT(a_clear_empties, cmd.clr, (used_q == '0) && !active_q, "clear left bindings")
	`PPBT_ASSERT_IMP(a_commit_bind, cmd.commit, (cmd_s1 == CMD_BIND) && (res_sts_q == ST_OK), "bad commit")
endmodule

// ===== design/path_prefix_binding_table_unit.sv =====
// Top level of the path prefix binding table.
//  channel | dir | tdata (low bit up)                        | tuser  | tlast
//  s_      | in  | ch[7:0] bind_handle[39:8] bind_mode[40]   | cmd    | last
//  m_      | out | found_handle[31:0] matched_length[36:32]  | status | -
//          |     | found_mode[37]                            |        |
// A character that does not end a path is loaded and compared; one that ends it
// is also checked against every entry (one entry checked per cycle) and decided,
// and a bind copies its n prefix characters before finishing. A clear goes straight to finish.
// arst_n clears all bindings at once; no clearing pass is needed.
// A result waits in the output register; the next beat is taken meanwhile, and
// a new result stalls only while the previous one has not been taken.
module path_prefix_binding_table_unit #(
	parameter int unsigned MAX_BINDINGS = 8,
	parameter int unsigned PREFIX_CHARS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // ch, bind_handle, bind_mode, zero pad
	input  logic [1:0]  s_tuser,   // cmd
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // found_handle, matched_length, found_mode, zero pad
	output logic [2:0]  m_tuser    // status
);
	import ppbt_pkg::*;

	dp_cmd_t dcmd;
	dp_sts_t dsts;

	ppbt_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_clear (cmd_t'(s_tuser) == CMD_CLEAR),
		.in_ready (s_tready),
		.sts      (dsts),
		.cmd      (dcmd)
	);

	ppbt_dp #(
		.MAX_BINDINGS (MAX_BINDINGS),
		.PREFIX_CHARS (PREFIX_CHARS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dcmd),
		.sts        (dsts),
		.in_cmd     (s_tuser),
		.in_ch      (s_tdata[7:0]),
		.in_last    (s_tlast),
		.in_handle  (s_tdata[39:8]),
		.in_mode    (s_tdata[40]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_handle (m_tdata[31:0]),
		.out_length (m_tdata[36:32]),
		.out_mode   (m_tdata[37])
	);

	assign m_tdata[39:38] = 2'b00;
endmodule
